// File: design/ldf_pkg.sv
package ldf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 32;
  localparam int unsigned KindW = 3;
  localparam int unsigned HdrW  = 2;

  localparam logic [LenW-1:0] MaxLenReset = 32'd1048576;
  localparam logic [HdrW-1:0] HdrLast     = 2'd3;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER   = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_ZERO     = 3'd2,
    KIND_OVERSIZE = 3'd3,
    KIND_DROPPED  = 3'd4
  } ldf_kind_e;

  typedef struct packed {
    ldf_kind_e        kind;
    logic [ByteW-1:0] payload_byte;
    logic             block_end;
    logic [LenW-1:0]  block_length;
  } ldf_result_t;

endpackage

// File: design/length_prefix_deframer_core.sv
// an accepted word is held in the input register, then parsed into the result register
// throughput: one word per cycle while the sink does not stall; the result register frees and refills in the same cycle
// the input stalls only while the result register holds a word that the sink stalls
// reset (rst_ni low, asynchronous): parser waits for a header, halt flag clear,
// max_block_length back to 1048576, both word registers empty
module length_prefix_deframer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ldf_pkg::LenW-1:0]   cfg_data_i,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ldf_pkg::ByteW-1:0]  rx_byte_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ldf_pkg::KindW-1:0]  kind_o,
  output logic [ldf_pkg::ByteW-1:0]  payload_byte_o,
  output logic                       block_end_o,
  output logic [ldf_pkg::LenW-1:0]   block_length_o
);
  import ldf_pkg::*;

  // max length register, always writable
  logic [LenW-1:0] max_len_q;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;

  logic        in_take;
  logic        step;
  logic        can_load;
  ldf_result_t result;
  ldf_result_t result_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // input word waits here only while the result register cannot take a new word
  assign in_stall_o = in_valid_q && !can_load;
  assign in_take    = in_valid_i && !in_stall_o;
  // the held word is parsed and moved to the result register in one step
  assign step       = in_valid_q && can_load;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // parser state and per-word decode
  ldf_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .result_o  (result)
  );

  // result register toward the sink
  ldf_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (result),
    .out_stall_i (out_stall_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .result_o    (result_q)
  );

  assign kind_o         = result_q.kind;
  assign payload_byte_o = result_q.payload_byte;
  assign block_end_o    = result_q.block_end;
  assign block_length_o = result_q.block_length;

`ifndef NO_ASSERTIONS
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o) else $error("parsed word did not reach result register");
  a_end_on_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_end_o |-> kind_o == KIND_PAYLOAD)
    else $error("block end on non-payload word");
  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !can_load |=> in_valid_q) else $error("stalled input word lost");
`endif

endmodule

// File: design/ldf_parse.sv
module ldf_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ldf_pkg::ByteW-1:0]  byte_i,
  input  logic [ldf_pkg::LenW-1:0]   max_len_i,
  output ldf_pkg::ldf_result_t       result_o
);
  import ldf_pkg::*;

  logic [HdrW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic            in_payload_q, in_payload_d;
  logic [LenW-1:0] pay_cnt_q, pay_cnt_d;
  logic            halted_q, halted_d;

  logic [LenW-1:0] len_asm;
  logic [LenW-1:0] pay_cnt_inc;

  // header bytes shift in msb first
  assign len_asm     = (hdr_cnt_q == '0) ? {{(LenW-ByteW){1'b0}}, byte_i}
                                         : {len_q[LenW-ByteW-1:0], byte_i};
  assign pay_cnt_inc = pay_cnt_q + {{(LenW-1){1'b0}}, 1'b1};

  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    len_d        = len_q;
    in_payload_d = in_payload_q;
    pay_cnt_d    = pay_cnt_q;
    halted_d     = halted_q;
    result_o.kind         = KIND_DROPPED;
    result_o.payload_byte = '0;
    result_o.block_end    = 1'b0;
    result_o.block_length = '0;
    if (halted_q) begin
      result_o.block_length = len_q;
    end else if (!in_payload_q) begin
      len_d         = len_asm;
      result_o.kind = KIND_HEADER;
      if (hdr_cnt_q == HdrLast) begin
        hdr_cnt_d             = '0;
        result_o.block_length = len_asm;
        if (len_asm == '0) begin
          result_o.kind = KIND_ZERO;
        end else if (len_asm > max_len_i) begin
          result_o.kind = KIND_OVERSIZE;
          halted_d      = 1'b1;
        end else begin
          in_payload_d = 1'b1;
          pay_cnt_d    = '0;
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + {{(HdrW-1){1'b0}}, 1'b1};
      end
    end else begin
      result_o.kind         = KIND_PAYLOAD;
      result_o.payload_byte = byte_i;
      result_o.block_length = len_q;
      pay_cnt_d             = pay_cnt_inc;
      if (pay_cnt_inc >= len_q) begin
        result_o.block_end = 1'b1;
        in_payload_d       = 1'b0;
        pay_cnt_d          = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q    <= '0;
      len_q        <= '0;
      in_payload_q <= 1'b0;
      pay_cnt_q    <= '0;
      halted_q     <= 1'b0;
    end else if (step_i) begin
      hdr_cnt_q    <= hdr_cnt_d;
      len_q        <= len_d;
      in_payload_q <= in_payload_d;
      pay_cnt_q    <= pay_cnt_d;
      halted_q     <= halted_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt flag cleared without reset");
  a_hdr_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> hdr_cnt_q == '0) else $error("header count nonzero in payload");
  a_pay_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> pay_cnt_q < len_q) else $error("payload count reached length");
`endif

endmodule

// File: design/ldf_out_reg.sv
module ldf_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ldf_pkg::ldf_result_t  result_i,
  input  logic                  out_stall_i,
  output logic                  can_load_o,
  output logic                  out_valid_o,
  output ldf_pkg::ldf_result_t  result_o
);
  import ldf_pkg::*;

  logic        valid_q, valid_d;
  ldf_result_t data_q;

  assign can_load_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

// File: tb/tb_length_prefix_deframer_core.sv
module tb_length_prefix_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ldf_pkg::*;

  // run limit in clock cycles, far above the slowest correct run
  localparam int unsigned CycleLimit = 400000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [LenW-1:0]   cfg_data_i    = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  rx_byte_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [KindW-1:0]  kind_o;
  logic [ByteW-1:0]  payload_byte_o;
  logic              block_end_o;
  logic [LenW-1:0]   block_length_o;

  length_prefix_deframer_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .block_end_o    (block_end_o),
    .block_length_o (block_length_o)
  );

  // bytes waiting to be sent and deframed results waiting to arrive
  logic [ByteW-1:0] link_bytes[$];
  ldf_result_t      deframed_due[$];

  // deframer shadow state
  logic [HdrW-1:0]  hdr_cnt   = '0;
  logic [LenW-1:0]  len_acc   = '0;
  logic             in_body   = 1'b0;
  logic [LenW-1:0]  body_cnt  = '0;
  logic             is_halted = 1'b0;
  logic [LenW-1:0]  max_len   = MaxLenReset;

  // 0: sender idles rarely, sink stalls often; 1: the other way round; 2: no idling
  int unsigned      idle_mode   = 0;
  logic             sender_hold = 1'b0;
  int unsigned      err_count   = 0;
  int unsigned      cycle_count = 0;
  ldf_result_t      accepted_res;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // one result word per accepted byte, mirroring the parser
  task automatic deframe_byte(input logic [ByteW-1:0] b, output ldf_result_t r);
    r = '0;
    r.kind = KIND_HEADER;
    if (is_halted) begin
      // after the halt every byte is dropped, state frozen
      r.kind = KIND_DROPPED;
      r.block_length = len_acc;
    end else if (!in_body) begin
      // big-endian length assembly
      len_acc = (hdr_cnt == '0) ? {{(LenW-ByteW){1'b0}}, b} : {len_acc[LenW-ByteW-1:0], b};
      if (hdr_cnt == HdrLast) begin
        hdr_cnt = '0;
        r.block_length = len_acc;
        if (len_acc == '0) begin
          r.kind = KIND_ZERO;
        end else if (len_acc > max_len) begin
          r.kind = KIND_OVERSIZE;
          is_halted = 1'b1;
        end else begin
          in_body = 1'b1;
          body_cnt = '0;
        end
      end else begin
        hdr_cnt = hdr_cnt + 1'b1;
      end
    end else begin
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      r.block_length = len_acc;
      body_cnt = body_cnt + 1'b1;
      if (body_cnt >= len_acc) begin
        r.block_end = 1'b1;
        in_body = 1'b0;
        body_cnt = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [LenW-1:0] got,
                                 input logic [LenW-1:0] want);
    err_count++;
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
  endtask

  // driver: a byte goes out whenever the link is free and the sender does not idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(rx_byte_i, accepted_res);
        deframed_due.push_back(accepted_res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (link_bytes.size() > 0 && !sender_hold &&
            $urandom_range(0, 99) >= ((idle_mode == 0) ? 8 : (idle_mode == 1) ? 49 : 0)) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= link_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (deframed_due.size() == 0) begin
          report_mismatch("unexpected result word, kind", LenW'(kind_o), '0);
        end else begin
          accepted_res = deframed_due.pop_front();
          if (kind_o !== accepted_res.kind)
            report_mismatch("kind", LenW'(kind_o), LenW'(accepted_res.kind));
          if (payload_byte_o !== accepted_res.payload_byte)
            report_mismatch("payload_byte", LenW'(payload_byte_o),
                            LenW'(accepted_res.payload_byte));
          if (block_end_o !== accepted_res.block_end)
            report_mismatch("block_end", LenW'(block_end_o), LenW'(accepted_res.block_end));
          if (block_length_o !== accepted_res.block_length)
            report_mismatch("block_length", block_length_o, accepted_res.block_length);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) <
                      ((idle_mode == 0) ? 49 : (idle_mode == 1) ? 8 : 0));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_header(input logic [LenW-1:0] len);
    link_bytes.push_back(len[31:24]);
    link_bytes.push_back(len[23:16]);
    link_bytes.push_back(len[15:8]);
    link_bytes.push_back(len[7:0]);
  endtask

  // a complete block with random payload
  task automatic push_block(input logic [LenW-1:0] len);
    push_header(len);
    for (int unsigned i = 0; i < len; i++)
      link_bytes.push_back(ByteW'($urandom));
  endtask

  // mostly short blocks, now and then one long enough for a two-byte length
  task automatic push_random_blocks(input int unsigned n_bytes);
    int unsigned queued;
    int unsigned cap;
    int unsigned len;
    queued = 0;
    while (queued < n_bytes) begin
      cap = ($urandom_range(0, 19) == 0) ? 600 : 12;
      if (max_len < cap) cap = max_len;
      len = $urandom_range(0, cap);
      push_block(len);
      queued += len + 4;
    end
  endtask

  // sender has nothing left and every result word has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (link_bytes.size() != 0 || in_valid_i || deframed_due.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // register write while the parser is idle
  task automatic write_max_len(input logic [LenW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    max_len = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset maximum: zero lengths back to back, short blocks with extreme bytes
    idle_mode = 0;
    push_header(32'd0);
    push_header(32'd0);
    push_header(32'd1);
    link_bytes.push_back(8'h00);
    push_header(32'd2);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h55);
    push_header(32'd3);
    link_bytes.push_back(8'hAA);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(8'h80);
    push_random_blocks(300);
    wait_drained();

    // small maximum, a block of exactly the maximum length
    write_max_len(32'd5);
    idle_mode = 1;
    push_block(32'd5);
    push_random_blocks(300);
    wait_drained();

    // largest maximum; sender holds mid phase until all results are back
    write_max_len(32'hFFFF_FFFF);
    idle_mode = 2;
    push_random_blocks(150);
    @(posedge clk_i);
    sender_hold <= 1'b1;
    do @(posedge clk_i);
    while (in_valid_i || deframed_due.size() != 0);
    sender_hold <= 1'b0;
    push_random_blocks(150);
    wait_drained();

    // maximum of one
    write_max_len(32'd1);
    idle_mode = 0;
    push_block(32'd1);
    push_random_blocks(250);
    wait_drained();

    // random moderate maximum
    write_max_len(LenW'($urandom_range(2, 700)));
    idle_mode = 1;
    push_random_blocks(300);
    wait_drained();

    // maximum of zero: zero lengths still skip, any other length halts the parser
    write_max_len(32'd0);
    idle_mode = 2;
    push_header(32'd0);
    push_header(32'd0);
    if ($urandom_range(0, 1) == 0)
      push_header(32'hFFFF_FFFF);
    else
      push_header(LenW'($urandom) | 32'h1);
    // everything after the halt is dropped
    for (int i = 0; i < 60; i++)
      link_bytes.push_back(ByteW'($urandom));
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (err_count == 0 && deframed_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
